/* src/ccws_pkg.sv */
// Shared types, character codes and helper functions for the CSS minifier core.
package ccws_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_COMMENT    = 2'd1,
    MODE_STRING     = 2'd2,
    MODE_STRING_ESC = 2'd3
  } scan_mode_e;

  typedef enum logic {
    REG_STRIP_WHITESPACE = 1'b0,
    REG_STRIP_COMMENTS   = 1'b1
  } cfg_reg_e;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;

  // Result queue depth and the fill level above which no new beat is taken.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ACCEPT_MAX = CNT_W'(QUEUE_DEPTH - 2);

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       stream_end;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_CR) || (b == CH_FF);
  endfunction

  function automatic logic is_edge(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_COLON) ||
           (b == CH_SEMI) || (b == CH_COMMA) || (b == CH_LPAREN) ||
           (b == CH_RPAREN) || (b == CH_NUL);
  endfunction

endpackage

/* src/css_comment_whitespace_stripper_core.sv */
// Top level of the CSS minifier: scanner state machine and result queue.
//
// Source text enters on the input channel one byte per beat (in_byte_i, with
// in_last_i on the final byte of a stream). Minified bytes leave on the
// output channel, one per beat; out_last_o marks the last byte produced by a
// given source byte and out_stream_end_o marks the final byte of the stream.
// Both channels use valid/stall: a beat moves when valid is high and stall is
// low. Two mode registers are written over the configuration channel
// (index 0 strips whitespace, index 1 strips comments); cfg_ready_o is always
// high, and writes are expected only while the core is idle.
//
// Each accepted byte is scanned in the same cycle and its results (zero, one
// or two bytes) are written into a four-entry result queue whose registered
// head drives the output port. A byte is taken every cycle while the queue
// holds at most two entries; bytes that yield two results (a held slash
// followed by another byte, or a collapsed space followed by a byte) drain at
// one per cycle while the receiver does not stall, so the output port's one
// beat per cycle sets the sustained rate.
// When the receiver stalls, the queue fills and in_stall_o rises once more
// than two entries wait. Reset empties the queue, returns the scanner to
// plain text and sets both mode registers to one.
module css_comment_whitespace_stripper_core
  import ccws_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic       cfg_data_i,
  // Source byte channel.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  // Minified byte channel.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_stream_end_o
);

  // Mode registers.
  logic strip_ws_q, strip_cm_q;

  // Scanner state.
  scan_mode_e mode_q, mode_d;
  logic       quote_single_q, quote_single_d;
  logic       slash_q, slash_d;
  logic       star_q, star_d;
  logic       pend_q, pend_d;
  logic [7:0] prev_q, prev_d;
  logic       empty_q, empty_d;

  // Results of the current byte.
  logic [1:0] n_res;
  logic [7:0] b0, b1;
  result_t    r0, r1;

  // Result queue; entry 0 is the head.
  result_t          q_q [QUEUE_DEPTH];
  result_t          q_d [QUEUE_DEPTH];
  result_t          q_sh [QUEUE_DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d, base;

  logic accept, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_ws_q <= 1'b1;
      strip_cm_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_STRIP_WHITESPACE: strip_ws_q <= cfg_data_i;
        REG_STRIP_COMMENTS:   strip_cm_q <= cfg_data_i;
        default:              strip_ws_q <= strip_ws_q;
      endcase
    end
  end

  assign in_stall_o  = (cnt_q > ACCEPT_MAX);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;

  // Scanner: works out the results of one byte and the state it leaves.
  // The two result slots default to the input byte, so the byte itself is
  // emitted simply by counting it in; only a leading slash, a collapsed space
  // or a comment opener overrides the first slot.
  always_comb begin
    logic done;
    done           = 1'b0;
    mode_d         = mode_q;
    quote_single_d = quote_single_q;
    slash_d        = slash_q;
    star_d         = star_q;
    pend_d         = pend_q;
    prev_d         = prev_q;
    empty_d        = empty_q;
    n_res          = 2'd0;
    b0             = in_byte_i;
    b1             = in_byte_i;

    unique case (mode_q)
      MODE_COMMENT: begin
        if (!strip_cm_q) begin
          n_res   = 2'd1;
          prev_d  = in_byte_i;
          empty_d = 1'b0;
        end
        if (star_q && (in_byte_i == CH_SLASH)) begin
          mode_d = MODE_NORMAL;
          star_d = 1'b0;
        end else begin
          star_d = (in_byte_i == CH_STAR);
        end
      end
      MODE_STRING_ESC: begin
        n_res   = 2'd1;
        prev_d  = in_byte_i;
        empty_d = 1'b0;
        mode_d  = MODE_STRING;
      end
      MODE_STRING: begin
        n_res   = 2'd1;
        prev_d  = in_byte_i;
        empty_d = 1'b0;
        if (in_byte_i == (quote_single_q ? CH_SQUOTE : CH_DQUOTE)) begin
          mode_d = MODE_NORMAL;
        end else if (in_byte_i == CH_BSLASH) begin
          mode_d = MODE_STRING_ESC;
        end
      end
      default: begin
        // A held slash is resolved first; it never coexists with a pending
        // space, so at most two results come out of this branch.
        if (slash_q) begin
          slash_d = 1'b0;
          if (in_byte_i == CH_STAR) begin
            mode_d = MODE_COMMENT;
            star_d = 1'b0;
            done   = 1'b1;
            if (!strip_cm_q) begin
              n_res   = 2'd2;
              b0      = CH_SLASH;
              b1      = CH_STAR;
              prev_d  = CH_STAR;
              empty_d = 1'b0;
            end
          end else begin
            n_res   = 2'd1;
            b0      = CH_SLASH;
            prev_d  = CH_SLASH;
            empty_d = 1'b0;
          end
        end
        if (!done && strip_ws_q && is_ws(in_byte_i)) begin
          pend_d = 1'b1;
          done   = 1'b1;
        end
        if (!done) begin
          if (pend_q) begin
            pend_d = 1'b0;
            if (!(empty_q || is_edge(prev_q) || is_edge(in_byte_i))) begin
              n_res = 2'd1;
              b0    = CH_SPACE;
            end
          end
          if ((in_byte_i == CH_SLASH) && !in_last_i) begin
            slash_d = 1'b1;
          end else begin
            n_res   = n_res + 2'd1;
            prev_d  = in_byte_i;
            empty_d = 1'b0;
            if ((in_byte_i == CH_DQUOTE) || (in_byte_i == CH_SQUOTE)) begin
              mode_d         = MODE_STRING;
              quote_single_d = (in_byte_i == CH_SQUOTE);
            end
          end
        end
      end
    endcase

    // The end of a stream returns the scanner to its starting state and
    // drops any pending space.
    if (in_last_i) begin
      mode_d         = MODE_NORMAL;
      quote_single_d = 1'b0;
      slash_d        = 1'b0;
      star_d         = 1'b0;
      pend_d         = 1'b0;
      prev_d         = CH_NUL;
      empty_d        = 1'b1;
    end
  end

  always_comb begin
    r0.byte_val   = b0;
    r0.last       = (n_res == 2'd1);
    r0.stream_end = (n_res == 2'd1) && in_last_i;
    r1.byte_val   = b1;
    r1.last       = 1'b1;
    r1.stream_end = in_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_NORMAL;
      quote_single_q <= 1'b0;
      slash_q        <= 1'b0;
      star_q         <= 1'b0;
      pend_q         <= 1'b0;
      prev_q         <= CH_NUL;
      empty_q        <= 1'b1;
    end else if (accept) begin
      mode_q         <= mode_d;
      quote_single_q <= quote_single_d;
      slash_q        <= slash_d;
      star_q         <= star_d;
      pend_q         <= pend_d;
      prev_q         <= prev_d;
      empty_q        <= empty_d;
    end
  end

  // Result queue: the head pops toward the output, new results land right
  // behind the surviving entries.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      q_sh[i] = pop ? q_q[i+1] : q_q[i];
    end
    q_sh[QUEUE_DEPTH-1] = q_q[QUEUE_DEPTH-1];

    base = cnt_q - CNT_W'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (accept && (n_res != 2'd0) && (IDX_W'(i) == base[IDX_W-1:0])) begin
        q_d[i] = r0;
      end else if (accept && (n_res == 2'd2) &&
                   (IDX_W'(i) == IDX_W'(base + CNT_W'(1)))) begin
        q_d[i] = r1;
      end else begin
        q_d[i] = q_sh[i];
      end
    end

    cnt_d = base + (accept ? CNT_W'(n_res) : '0);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign out_byte_o       = q_q[0].byte_val;
  assign out_last_o       = q_q[0].last;
  assign out_stream_end_o = q_q[0].stream_end;

  // The queue never holds more entries than it has.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // A stream-end beat always closes the results of its source byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stream_end_o |-> out_last_o)
    else $error("stream end without last flag");

  // After the final byte of a stream the scanner is back in plain text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> (mode_q == MODE_NORMAL) && !slash_q && !pend_q && empty_q)
    else $error("scanner not cleared at end of stream");

  // A held slash never coexists with a pending space.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(slash_q && pend_q))
    else $error("held slash and pending space together");

endmodule
